### rtl/core/lcdseq_pkg.sv
package lcdseq_pkg;

  // Operation codes carried in the operation field.
  localparam logic [2:0] OP_INIT = 3'd0;
  localparam logic [2:0] OP_CMD  = 3'd1;
  localparam logic [2:0] OP_DATA = 3'd2;
  localparam logic [2:0] OP_CURS = 3'd3;
  localparam logic [2:0] OP_TIME = 3'd4;

  // Highest index of the strobe sequence for each operation.
  localparam logic [3:0] LAST_INIT = 4'd13;
  localparam logic [3:0] LAST_TIME = 4'd11;
  localparam logic [3:0] LAST_BYTE = 4'd1;

  // Timing values in microseconds.
  localparam logic [17:0] WAIT_POWER_UP = 18'd200000;
  localparam logic [17:0] WAIT_HI_US    = 18'd20;
  localparam logic [15:0] WAIT_LONG_US  = 16'd50000;
  localparam logic [15:0] WAIT_MID_US   = 16'd10000;
  localparam logic [15:0] WAIT_CMD_US   = 16'd5000;
  localparam logic [15:0] WAIT_DATA_US  = 16'd10;

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_COLON = 8'h3A;
  localparam logic [6:0] TIME_MAX    = 7'd99;
  localparam logic [6:0] TEN         = 7'd10;

  // Result of the shared decimal digit unit.
  typedef struct packed {
    logic       done;
    logic [3:0] tens;
    logic [3:0] ones;
  } div_res_t;

  // DDRAM base address of each display row.
  function automatic logic [7:0] row_base(input logic [1:0] row);
    logic [7:0] b;
    case (row)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hC0;
      2'd2:    b = 8'h94;
      default: b = 8'hD4;
    endcase
    return b;
  endfunction

  // Command bytes sent after the raw wake-up nibbles of init.
  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h01;
      3'd1:    c = 8'h06;
      3'd2:    c = 8'h0F;
      3'd3:    c = 8'h0E;
      default: c = 8'h0D;
    endcase
    return c;
  endfunction

endpackage

### rtl/core/lcdseq_div10.sv
// Splits a value below 100 into its decimal tens and ones digits by
// subtracting ten once per cycle, at most nine iterations.
module lcdseq_div10
  import lcdseq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [6:0] value,
  output div_res_t   res
);

  logic [6:0] rem;
  logic [3:0] quo;
  logic       busy;

  // Iterate until the remainder drops below ten.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && rem < TEN) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= value;
      quo <= 4'd0;
    end else if (busy && rem >= TEN) begin
      rem <= rem - TEN;
      quo <= quo + 4'd1;
    end
  end

  assign res.done = busy && (rem < TEN);
  assign res.tens = quo;
  assign res.ones = rem[3:0];

endmodule

### rtl/core/char_lcd_nibble_write_sequencer_top.sv
// Character LCD strobe sequencer for a 4-bit bus. Each input transaction is
// one operation (init, command byte, data byte, set cursor, show time) and
// yields a run of output transactions, one per enable strobe, carrying RS,
// the bus nibble D7..D4 and the waits before and after the strobe in
// microseconds; tlast marks the final strobe of the operation. Unknown
// operation codes are taken and produce nothing. The block accepts one
// operation at a time. Once accepted, it issues one strobe per cycle while
// the output side is ready. Show time first converts minutes and seconds to
// decimal digits with a shared subtract-by-ten unit. Minutes and seconds
// above 99 show as 99.
module char_lcd_nibble_write_sequencer_top
  import lcdseq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] operation, [10:3] data_byte, [12:11] row, [18:13] col,
  // [25:19] minutes, [32:26] seconds, [39:33] zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] reg_select, [4:1] nibble, [22:5] wait_before_us,
  // [38:23] wait_after_us, [39] zero
  output logic [39:0] m_axis_tdata,
  output logic        m_axis_tlast
);

  localparam logic [1:0] ST_IDLE     = 2'd0;
  localparam logic [1:0] ST_CONV_MIN = 2'd1;
  localparam logic [1:0] ST_CONV_SEC = 2'd2;
  localparam logic [1:0] ST_EMIT     = 2'd3;

  logic [1:0] state;
  logic [3:0] step;
  logic [2:0] op;
  logic [7:0] byte_in;
  logic [7:0] addr;
  logic [6:0] sec_sat;
  logic [3:0] min_tens, min_ones, sec_tens, sec_ones;

  logic       in_accept;
  logic [2:0] in_op;
  logic [6:0] in_min, in_sec, in_min_sat, in_sec_sat;
  logic       div_start;
  logic [6:0] div_value;
  div_res_t   div_res;

  logic       load;
  logic [3:0] last_step;
  logic [2:0] byte_idx;
  logic [7:0] cur_byte;
  logic       cur_rs;
  logic [3:0] cur_nib;
  logic [17:0] cur_wb;
  logic [15:0] cur_wa;

  logic        out_rs;
  logic [3:0]  out_nib;
  logic [17:0] out_wb;
  logic [15:0] out_wa;

  // Input field extraction and saturation of the time fields.
  assign in_op      = s_axis_tdata[2:0];
  assign in_min     = s_axis_tdata[25:19];
  assign in_sec     = s_axis_tdata[32:26];
  assign in_min_sat = (in_min > TIME_MAX) ? TIME_MAX : in_min;
  assign in_sec_sat = (in_sec > TIME_MAX) ? TIME_MAX : in_sec;

  assign s_axis_tready = (state == ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  // The digit unit runs for minutes first, then for seconds.
  assign div_start = (in_accept && in_op == OP_TIME) ||
                     (state == ST_CONV_MIN && div_res.done);
  assign div_value = (state == ST_CONV_MIN) ? sec_sat : in_min_sat;

  lcdseq_div10 u_div10 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .value (div_value),
    .res   (div_res)
  );

  // Latch the operands of an accepted transaction.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op      <= in_op;
      byte_in <= s_axis_tdata[10:3];
      addr    <= row_base(s_axis_tdata[12:11]) + {2'b00, s_axis_tdata[18:13]};
      sec_sat <= in_sec_sat;
    end
    if (state == ST_CONV_MIN && div_res.done) begin
      min_tens <= div_res.tens;
      min_ones <= div_res.ones;
    end
    if (state == ST_CONV_SEC && div_res.done) begin
      sec_tens <= div_res.tens;
      sec_ones <= div_res.ones;
    end
  end

  // Index of the final strobe for the current operation.
  always_comb begin
    case (op)
      OP_INIT: last_step = LAST_INIT;
      OP_TIME: last_step = LAST_TIME;
      default: last_step = LAST_BYTE;
    endcase
  end

  // Pick the byte being sent and its RS level.
  always_comb begin
    byte_idx = (op == OP_INIT) ? (step[3:1] - 3'd2) : step[3:1];
    cur_rs   = 1'b0;
    cur_byte = addr;
    case (op)
      OP_INIT: cur_byte = init_cmd(byte_idx);
      OP_CMD:  cur_byte = byte_in;
      OP_DATA: begin
        cur_byte = byte_in;
        cur_rs   = 1'b1;
      end
      OP_TIME: begin
        cur_rs = (byte_idx != 3'd0);
        case (byte_idx)
          3'd0:    cur_byte = addr;
          3'd1:    cur_byte = ASCII_ZERO | {4'h0, min_tens};
          3'd2:    cur_byte = ASCII_ZERO | {4'h0, min_ones};
          3'd3:    cur_byte = ASCII_COLON;
          3'd4:    cur_byte = ASCII_ZERO | {4'h0, sec_tens};
          default: cur_byte = ASCII_ZERO | {4'h0, sec_ones};
        endcase
      end
      default: cur_byte = addr;
    endcase
  end

  // Nibble and waits of the current strobe.
  always_comb begin
    if (op == OP_INIT && step < 4'd4) begin
      cur_nib = (step == 4'd3) ? 4'h2 : 4'h3;
      cur_wb  = (step == 4'd0) ? WAIT_POWER_UP : 18'd0;
      cur_wa  = (step < 4'd2) ? WAIT_LONG_US : WAIT_MID_US;
    end else if (!step[0]) begin
      cur_nib = cur_byte[7:4];
      cur_wb  = WAIT_HI_US;
      cur_wa  = 16'd0;
    end else begin
      cur_nib = cur_byte[3:0];
      cur_wb  = 18'd0;
      cur_wa  = cur_rs ? WAIT_DATA_US : WAIT_CMD_US;
    end
  end

  assign load = (state == ST_EMIT) && (!m_axis_tvalid || m_axis_tready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 4'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          step <= 4'd0;
          if (in_accept) begin
            if (in_op == OP_TIME) begin
              state <= ST_CONV_MIN;
            end else if (in_op == OP_INIT || in_op == OP_CMD ||
                         in_op == OP_DATA || in_op == OP_CURS) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_CONV_MIN: begin
          if (div_res.done) begin
            state <= ST_CONV_SEC;
          end
        end
        ST_CONV_SEC: begin
          if (div_res.done) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (load) begin
            step <= step + 4'd1;
            if (step == last_step) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rs       <= cur_rs;
      out_nib      <= cur_nib;
      out_wb       <= cur_wb;
      out_wa       <= cur_wa;
      m_axis_tlast <= (step == last_step);
    end
  end

  assign m_axis_tdata = {1'b0, out_wa, out_wb, out_nib, out_rs};

  // The strobe index never runs past the longest sequence.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (step <= LAST_INIT))
    else $error("strobe index out of range");

  // Digits from the shared unit are decimal.
  a_digits: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (div_res.tens <= 4'd9 && div_res.ones <= 4'd9))
    else $error("digit unit produced a non-decimal digit");

  // No new transaction is taken while digits are being converted.
  a_conv_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV_MIN || state == ST_CONV_SEC) |-> !s_axis_tready)
    else $error("input accepted during digit conversion");

endmodule

### test/tb.sv
module tb
  import lcdseq_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_OPS = 350;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam logic RS_CMD = 1'b0;
  localparam logic RS_DATA = 1'b1;

  // One LCD operation as it travels on the input stream.
  typedef struct {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic [1:0] row;
    logic [5:0] col;
    logic [6:0] minutes;
    logic [6:0] seconds;
  } lcd_op_t;

  // One enable strobe as it appears on the output stream.
  typedef struct {
    logic        reg_select;
    logic [3:0]  nibble;
    logic [17:0] wait_before;
    logic [15:0] wait_after;
    logic        pad;
    logic        last;
  } strobe_t;

  // Expands each accepted operation into its strobes and checks them in order.
  class lcd_strobe_scoreboard;
    strobe_t strobe_q[$];
    int      errors;

    function new();
      errors = 0;
    endfunction

    local function void push_strobe(logic rs, logic [3:0] nib, logic [17:0] lead,
                                    logic [15:0] after, logic fin);
      strobe_t s;
      s.reg_select  = rs;
      s.nibble      = nib;
      s.wait_before = lead;
      s.wait_after  = after;
      s.pad         = 1'b0;
      s.last        = fin;
      strobe_q.push_back(s);
    endfunction

    // A byte goes out high nibble first; the low nibble carries the settle time.
    local function void push_byte(logic rs, logic [7:0] b, logic fin);
      push_strobe(rs, b[7:4], WAIT_HI_US, 16'd0, 1'b0);
      push_strobe(rs, b[3:0], 18'd0, (rs == RS_DATA) ? WAIT_DATA_US : WAIT_CMD_US, fin);
    endfunction

    // The DDRAM address wraps at eight bits.
    local function logic [7:0] ddram_addr(logic [1:0] row, logic [5:0] col);
      logic [7:0] base;
      case (row)
        2'd0: base = 8'h80;
        2'd1: base = 8'hC0;
        2'd2: base = 8'h94;
        default: base = 8'hD4;
      endcase
      return base + {2'b00, col};
    endfunction

    // Two ASCII digits of a value that saturates at 99.
    local function void push_two_digits(logic [6:0] v, logic fin);
      logic [6:0] clipped;
      clipped = (v > TIME_MAX) ? TIME_MAX : v;
      push_byte(RS_DATA, ASCII_ZERO + {1'b0, clipped / TEN}, 1'b0);
      push_byte(RS_DATA, ASCII_ZERO + {1'b0, clipped % TEN}, fin);
    endfunction

    function void note_operation(lcd_op_t op);
      case (op.operation)
        OP_INIT: begin
          push_strobe(RS_CMD, 4'h3, WAIT_POWER_UP, WAIT_LONG_US, 1'b0);
          push_strobe(RS_CMD, 4'h3, 18'd0, WAIT_LONG_US, 1'b0);
          push_strobe(RS_CMD, 4'h3, 18'd0, WAIT_MID_US, 1'b0);
          push_strobe(RS_CMD, 4'h2, 18'd0, WAIT_MID_US, 1'b0);
          push_byte(RS_CMD, 8'h01, 1'b0);
          push_byte(RS_CMD, 8'h06, 1'b0);
          push_byte(RS_CMD, 8'h0F, 1'b0);
          push_byte(RS_CMD, 8'h0E, 1'b0);
          push_byte(RS_CMD, 8'h0D, 1'b1);
        end
        OP_CMD: push_byte(RS_CMD, op.data_byte, 1'b1);
        OP_DATA: push_byte(RS_DATA, op.data_byte, 1'b1);
        OP_CURS: push_byte(RS_CMD, ddram_addr(op.row, op.col), 1'b1);
        OP_TIME: begin
          push_byte(RS_CMD, ddram_addr(op.row, op.col), 1'b0);
          push_two_digits(op.minutes, 1'b0);
          push_byte(RS_DATA, ASCII_COLON, 1'b0);
          push_two_digits(op.seconds, 1'b1);
        end
        default: begin
          // Unknown codes are consumed without any strobe.
        end
      endcase
    endfunction

    local function void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_strobe(strobe_t got);
      strobe_t want;
      if (strobe_q.size() == 0) begin
        $error("strobe with nothing outstanding: rs %0b nibble 0x%0h", got.reg_select,
               got.nibble);
        errors++;
        return;
      end
      want = strobe_q.pop_front();
      check_field("reg_select", want.reg_select, got.reg_select);
      check_field("nibble", want.nibble, got.nibble);
      check_field("wait_before_us", want.wait_before, got.wait_before);
      check_field("wait_after_us", want.wait_after, got.wait_after);
      check_field("tdata padding", want.pad, got.pad);
      check_field("tlast", want.last, got.last);
    endfunction

    function int pending();
      return strobe_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  lcd_strobe_scoreboard strobe_board = new();

  int send_idle_pct = 27;
  int recv_idle_pct = 74;
  int hold_off_left = 0;
  int ops_sent = 0;
  int cycle_count = 0;

  char_lcd_nibble_write_sequencer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Output ready: random stalls, plus a long hold-off when one is requested.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Every accepted output transaction is checked against the oldest expected strobe.
  always @(posedge clk) begin
    strobe_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.reg_select  = m_axis_tdata[0];
      got.nibble      = m_axis_tdata[4:1];
      got.wait_before = m_axis_tdata[22:5];
      got.wait_after  = m_axis_tdata[38:23];
      got.pad         = m_axis_tdata[39];
      got.last        = m_axis_tlast;
      strobe_board.check_strobe(got);
    end
  end

  // Offers one operation and returns at the edge where it is accepted.
  task automatic send_op(input logic [2:0] operation, input logic [7:0] data_byte,
                         input logic [1:0] row, input logic [5:0] col,
                         input logic [6:0] minutes, input logic [6:0] seconds);
    lcd_op_t op;
    op.operation = operation;
    op.data_byte = data_byte;
    op.row       = row;
    op.col       = col;
    op.minutes   = minutes;
    op.seconds   = seconds;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, seconds, minutes, col, row, data_byte, operation};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    strobe_board.note_operation(op);
    ops_sent++;
  endtask

  // Same, with every field other than the operation drawn at random.
  task automatic send_random_op(input logic [2:0] operation);
    logic [6:0] minutes;
    logic [6:0] seconds;
    minutes = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(99));
    seconds = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(59));
    send_op(operation, 8'($urandom), 2'($urandom), 6'($urandom), minutes, seconds);
  endtask

  // A string: set cursor, then one data byte per character.
  task automatic send_random_string();
    int length;
    length = $urandom_range(8, 1);
    send_random_op(OP_CURS);
    for (int k = 0; k < length; k++) begin
      send_op(OP_DATA, 8'($urandom_range(126, 32)), 2'($urandom), 6'($urandom),
              7'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    int pick;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed operations: field extremes, address wrap, time saturation, unknown codes.
    send_op(OP_INIT, 8'h00, 2'd0, 6'd0, 7'd0, 7'd0);
    send_op(OP_CMD, 8'h00, 2'd3, 6'd63, 7'd127, 7'd127);
    send_op(OP_CMD, 8'hFF, 2'd0, 6'd0, 7'd0, 7'd0);
    send_op(OP_DATA, 8'h00, 2'd0, 6'd0, 7'd0, 7'd0);
    send_op(OP_DATA, 8'hFF, 2'd3, 6'd63, 7'd127, 7'd127);
    send_op(OP_DATA, 8'hA5, 2'd1, 6'd21, 7'd42, 7'd85);
    send_op(OP_CURS, 8'hFF, 2'd0, 6'd0, 7'd127, 7'd127);
    send_op(OP_CURS, 8'h00, 2'd1, 6'd39, 7'd0, 7'd0);
    send_op(OP_CURS, 8'h00, 2'd2, 6'd63, 7'd0, 7'd0);
    send_op(OP_CURS, 8'h00, 2'd3, 6'd63, 7'd0, 7'd0);
    send_op(OP_TIME, 8'h00, 2'd0, 6'd0, 7'd0, 7'd0);
    send_op(OP_TIME, 8'hFF, 2'd1, 6'd39, 7'd99, 7'd99);
    send_op(OP_TIME, 8'h00, 2'd2, 6'd5, 7'd100, 7'd127);
    send_op(OP_TIME, 8'h00, 2'd3, 6'd63, 7'd59, 7'd7);
    send_op(3'd5, 8'h12, 2'd1, 6'd3, 7'd4, 7'd5);
    send_op(3'd6, 8'hFF, 2'd3, 6'd63, 7'd127, 7'd127);
    send_op(3'd7, 8'h00, 2'd0, 6'd0, 7'd0, 7'd0);
    send_op(OP_CMD, 8'h5A, 2'd0, 6'd0, 7'd0, 7'd0);
    send_op(OP_INIT, 8'hFF, 2'd3, 6'd63, 7'd127, 7'd127);

    // Random traffic in three idling phases, with a long output hold-off in the last.
    ops_sent = 0;
    while (ops_sent < RANDOM_OPS) begin
      if (ops_sent >= 2 * RANDOM_OPS / 3 && send_idle_pct != 0) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_left = HOLD_OFF_CYCLES;
      end else if (ops_sent >= RANDOM_OPS / 3 && ops_sent < 2 * RANDOM_OPS / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 27;
      end
      pick = $urandom_range(99);
      if (pick < 5) send_random_op(OP_INIT);
      else if (pick < 35) send_random_string();
      else if (pick < 50) send_random_op(OP_TIME);
      else if (pick < 64) send_random_op(OP_CMD);
      else if (pick < 78) send_random_op(OP_DATA);
      else if (pick < 92) send_random_op(OP_CURS);
      else send_random_op(3'($urandom_range(7, 5)));
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b0;

    // Drain the outstanding strobes, then watch for anything extra.
    while (strobe_board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (strobe_board.errors == 0 && strobe_board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
